@@ hw/rtl/lrc_pkg.sv @@
// Shared types and constants for the LRU cache tag store.
// No dependencies; used by lrc_ctrl, lrc_dp and the top level.
package lrc_pkg;

    localparam int LINES    = 512;
    localparam int LINES_LG = 9;
    localparam int OFF_LG   = 5;
    localparam int TAG_W    = 27;
    localparam int RANK_W   = 9;
    localparam int IDX_W    = LINES_LG;
    localparam int CNT_W    = LINES_LG + 1;
    localparam int WL_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // largest associativity exponent; larger writes act as fully associative
    localparam logic [WL_W-1:0] WL_MAX = WL_W'(LINES_LG);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC = 2'd1;

    // access kinds
    localparam logic KIND_LOAD = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_UPDATE,
        S_UPD_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic load;     // capture access, clear scan results
        logic rd;       // read entry at way counter, advance
        logic upd;      // read is part of the update pass
        logic clr;      // clearing pass write, advance
        logic rst_cnt;  // way counter back to zero
        logic decide;   // pick target way, count hit
    } t_cmd;

    typedef struct packed {
        logic way_last;  // counter at last way of set
        logic clr_last;  // counter at last line
        logic need_upd;  // access changes the set
        logic inval;     // ways_log2 write this cycle
    } t_sts;

endpackage

@@ hw/rtl/lrc_ctrl.sv @@
// Controller state machine for the LRU cache tag store.
// Depends on lrc_pkg; drives lrc_dp through t_cmd, watches t_sts.
module lrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  lrc_pkg::t_sts   i_sts,
    output lrc_pkg::t_cmd   o_cmd,
    output logic            busy,
    output logic            o_valid
);

    lrc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrc_pkg::S_CLEAR:    if (i_sts.clr_last) n_state = lrc_pkg::S_IDLE;
            lrc_pkg::S_IDLE:     if (start) n_state = lrc_pkg::S_SCAN;
            lrc_pkg::S_SCAN:     if (i_sts.way_last) n_state = lrc_pkg::S_SCAN_END;
            lrc_pkg::S_SCAN_END: n_state = lrc_pkg::S_DECIDE;
            lrc_pkg::S_DECIDE:
                n_state = i_sts.need_upd ? lrc_pkg::S_UPDATE : lrc_pkg::S_DONE;
            lrc_pkg::S_UPDATE:   if (i_sts.way_last) n_state = lrc_pkg::S_UPD_END;
            lrc_pkg::S_UPD_END:  n_state = lrc_pkg::S_DONE;
            lrc_pkg::S_DONE:     n_state = lrc_pkg::S_IDLE;
            default:             n_state = lrc_pkg::S_IDLE;
        endcase
        if (i_sts.inval) n_state = lrc_pkg::S_CLEAR;
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            lrc_pkg::S_CLEAR:  o_cmd.clr = 1'b1;
            lrc_pkg::S_IDLE:   o_cmd.load = start;
            lrc_pkg::S_SCAN:   o_cmd.rd = 1'b1;
            lrc_pkg::S_DECIDE: begin
                o_cmd.decide  = 1'b1;
                o_cmd.rst_cnt = 1'b1;
            end
            lrc_pkg::S_UPDATE: begin
                o_cmd.rd  = 1'b1;
                o_cmd.upd = 1'b1;
            end
            default: o_cmd = '0;
        endcase
        if (i_sts.inval) begin
            o_cmd = '0;
            o_cmd.rst_cnt = 1'b1;
        end
    end

    assign busy    = (r_state != lrc_pkg::S_IDLE);
    assign o_valid = (r_state == lrc_pkg::S_DONE);

    // checks
    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_sts.inval) |=> (r_state == lrc_pkg::S_SCAN))
        else $error("accepted access did not start scan");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_upd_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrc_pkg::S_UPDATE && $past(r_state) != lrc_pkg::S_UPDATE)
        |-> $past(r_state) == lrc_pkg::S_DECIDE)
        else $error("update pass entered without decision");

endmodule

@@ hw/rtl/lrc_dp.sv @@
// Datapath of the LRU cache tag store: entry memory, way counter, scan results.
// Depends on lrc_pkg; commanded by lrc_ctrl.
module lrc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrc_pkg::t_cmd                 i_cmd,
    output lrc_pkg::t_sts                 o_sts,
    input  logic                          i_kind,
    input  logic [31:0]                   i_address,
    input  logic                          i_cfg_valid,
    input  logic [lrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_hit,
    output logic [31:0]                   o_hit_total
);

    lrc_pkg::t_entry mem [lrc_pkg::LINES];
    lrc_pkg::t_entry r_rd_data;

    logic [lrc_pkg::WL_W-1:0]   r_ways_log2;
    logic                       r_wa;
    logic [31:0]                r_hits;
    logic [lrc_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_rd_vld, r_rd_upd;
    logic [lrc_pkg::IDX_W-1:0]  r_rd_way;
    logic                       r_kind;
    logic [31:0]                r_addr;
    logic                       r_hit, r_free;
    logic [lrc_pkg::IDX_W-1:0]  r_hit_way, r_free_way, r_lru_way, r_tgt_way;
    logic [lrc_pkg::RANK_W-1:0] r_hit_rank, r_lru_rank;
    logic [lrc_pkg::CNT_W-1:0]  r_old_rank;

    logic [lrc_pkg::WL_W-1:0]   wl;
    logic [lrc_pkg::CNT_W-1:0]  ways;
    logic [lrc_pkg::IDX_W-1:0]  set_m, base, rd_idx, wr_idx;
    logic [lrc_pkg::TAG_W-1:0]  tag;
    logic [4:0]                 tshift;
    logic                       we;
    lrc_pkg::t_entry            wd;

    // geometry from clamped associativity
    assign wl     = (r_ways_log2 > lrc_pkg::WL_MAX) ? lrc_pkg::WL_MAX : r_ways_log2;
    assign ways   = lrc_pkg::CNT_W'(1) << wl;
    assign set_m  = r_addr[lrc_pkg::OFF_LG +: lrc_pkg::IDX_W] & ({lrc_pkg::IDX_W{1'b1}} >> wl);
    assign base   = lrc_pkg::IDX_W'(set_m << wl);
    assign tshift = 5'(lrc_pkg::OFF_LG + lrc_pkg::LINES_LG) - 5'(wl);
    assign tag    = lrc_pkg::TAG_W'(r_addr >> tshift);
    assign rd_idx = base | r_cnt[lrc_pkg::IDX_W-1:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_log2 <= lrc_pkg::WL_W'(1);
            r_wa        <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lrc_pkg::REG_WAYS_LOG2) r_ways_log2 <= i_cfg_data;
            if (i_cfg_index == lrc_pkg::REG_WRITE_ALLOC) r_wa <= i_cfg_data[0];
        end
    end

    // way / line counter and read pipe flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_rd_upd <= 1'b0;
        end else begin
            if (i_cmd.rst_cnt || i_cmd.load) r_cnt <= '0;
            else if (i_cmd.rd || i_cmd.clr) r_cnt <= r_cnt + 1'b1;
            r_rd_vld <= i_cmd.rd;
            r_rd_upd <= i_cmd.upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd_way <= r_cnt[lrc_pkg::IDX_W-1:0];
    end

    // write-back: clearing pass or rank/tag update
    always_comb begin
        we     = 1'b0;
        wr_idx = base | r_rd_way;
        wd     = r_rd_data;
        if (i_cmd.clr) begin
            we     = 1'b1;
            wr_idx = r_cnt[lrc_pkg::IDX_W-1:0];
            wd     = '0;
        end else if (r_rd_vld && r_rd_upd) begin
            we = 1'b1;
            if (r_rd_way == r_tgt_way) begin
                wd.valid = 1'b1;
                wd.rank  = '0;
                wd.tag   = tag;
            end else if (r_rd_data.valid &&
                         (lrc_pkg::CNT_W'(r_rd_data.rank) < r_old_rank)) begin
                wd.rank = r_rd_data.rank + 1'b1;
            end
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (we) mem[wr_idx] <= wd;
        if (i_cmd.rd) r_rd_data <= mem[rd_idx];
    end

    // access capture, scan results, decision, hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_lru_rank <= '0;
            r_lru_way  <= '0;
        end else if (r_rd_vld && !r_rd_upd) begin
            if (!r_rd_data.valid) begin
                if (!r_free) begin
                    r_free     <= 1'b1;
                    r_free_way <= r_rd_way;
                end
            end else begin
                if (r_rd_data.tag == tag && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_way  <= r_rd_way;
                    r_hit_rank <= r_rd_data.rank;
                end
                if (r_rd_data.rank >= r_lru_rank) begin
                    r_lru_rank <= r_rd_data.rank;
                    r_lru_way  <= r_rd_way;
                end
            end
        end else if (i_cmd.decide) begin
            if (r_hit) begin
                r_hits     <= r_hits + 32'd1;
                r_tgt_way  <= r_hit_way;
                r_old_rank <= lrc_pkg::CNT_W'(r_hit_rank);
            end else if (r_free) begin
                r_tgt_way  <= r_free_way;
                r_old_rank <= ways;
            end else begin
                r_tgt_way  <= r_lru_way;
                r_old_rank <= lrc_pkg::CNT_W'(r_lru_rank);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_addr <= i_address;
        end
    end

    assign o_sts.way_last = (r_cnt == ways - 1'b1);
    assign o_sts.clr_last = (r_cnt == lrc_pkg::CNT_W'(lrc_pkg::LINES - 1));
    assign o_sts.need_upd = r_hit || (r_kind == lrc_pkg::KIND_LOAD) || r_wa;
    assign o_sts.inval    = i_cfg_valid && (i_cfg_index == lrc_pkg::REG_WAYS_LOG2);

    assign o_hit       = r_hit;
    assign o_hit_total = r_hits;

    // checks
    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.decide |=> $stable(r_hits))
        else $error("hit count moved outside decision");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd) |-> (r_cnt < ways))
        else $error("way counter left the set");
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(r_rd_vld && r_rd_upd))
        else $error("clearing pass overlaps update");

endmodule

@@ hw/rtl/lru_set_assoc_cache_hit_counter_core.sv @@
// Top level of the LRU set-associative cache tag store with hit counter.
// Depends on lrc_pkg, lrc_ctrl and lrc_dp.
//
//  channel  | handshake                 | beat
//  ---------+---------------------------+--------------------------------
//  access   | start / busy              | i_kind, i_address
//  result   | o_valid (one cycle)       | o_hit, o_hit_total
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An access scans the ways of its set from the entry memory, one way a cycle,
// then, when the set changes, walks the set again to rewrite ranks; a store
// miss without write allocate skips that pass. The result strobe follows, and
// the controller goes back to idle before it takes the next access.
// After reset, and after each ways_log2 write, a clearing pass over all 512
// lines runs with busy high. Config is taken only while idle and start is low.
// The result strobe lasts one cycle; the receiver cannot stall.
module lru_set_assoc_cache_hit_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [31:0]                   i_address,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [31:0]                   o_hit_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    lrc_pkg::t_cmd cmd;
    lrc_pkg::t_sts sts;
    logic          cfg_we;

    // config beats only between accesses
    assign o_cfg_ready = !busy && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    lrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    lrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_address   (i_address),
        .i_cfg_valid (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_hit       (o_hit),
        .o_hit_total (o_hit_total)
    );

endmodule

@@ tb/tb_top.sv @@
// Testbench for the LRU set-associative cache tag store with hit counter.
// Depends on lrc_pkg and lru_set_assoc_cache_hit_counter_core.
`timescale 1ns / 1ps

module tb_top;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 1100;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_kind = 1'b0;
    logic [31:0]                   i_address = '0;
    logic                          o_valid;
    logic                          o_hit;
    logic [31:0]                   o_hit_total;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [lrc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [lrc_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    lru_set_assoc_cache_hit_counter_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow tag store
    logic [lrc_pkg::TAG_W-1:0]  shadow_tag   [lrc_pkg::LINES];
    logic                       shadow_valid [lrc_pkg::LINES];
    logic [lrc_pkg::RANK_W-1:0] shadow_rank  [lrc_pkg::LINES];
    logic [31:0]                shadow_hits;
    logic [3:0]                 cur_ways_lg;
    logic                       cur_walloc;

    typedef struct {
        logic        hit;
        logic [31:0] total;
    } t_lookup;

    t_lookup pending_lookups[$];
    int      err_count = 0;
    int      seen_results = 0;
    int      seen_hits = 0;
    int      sent_accesses = 0;
    longint  cyc = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH t=%0t %s got=%0h want=%0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic void flush_lines();
        for (int i = 0; i < lrc_pkg::LINES; i++) shadow_valid[i] = 1'b0;
    endfunction

    // bump ranks below old_rank, make way w MRU
    function automatic void promote(int base, int ways, int w, int old_rank);
        for (int j = 0; j < ways; j++)
            if (j != w && shadow_valid[base+j] && shadow_rank[base+j] < old_rank)
                shadow_rank[base+j] = shadow_rank[base+j] + 1'b1;
        shadow_rank[base+w] = '0;
    endfunction

    function automatic t_lookup lookup_line(logic kind, logic [31:0] addr);
        int wl, ways, sets_lg, set_no, base, tshift;
        int hit_way, free_way, lru_way, lru_rank;
        logic [lrc_pkg::TAG_W-1:0] tag;
        logic hit, have_free;
        t_lookup r;
        wl = (cur_ways_lg > lrc_pkg::LINES_LG) ? lrc_pkg::LINES_LG : int'(cur_ways_lg);
        ways = 1 << wl;
        sets_lg = lrc_pkg::LINES_LG - wl;
        set_no = int'((addr >> lrc_pkg::OFF_LG) & ((32'd1 << sets_lg) - 32'd1));
        tshift = lrc_pkg::OFF_LG + sets_lg;
        tag = lrc_pkg::TAG_W'(addr >> tshift);
        base = set_no << wl;
        hit = 0; have_free = 0;
        hit_way = 0; free_way = 0; lru_way = 0; lru_rank = 0;
        for (int j = 0; j < ways; j++) begin
            if (!shadow_valid[base+j]) begin
                if (!have_free) begin
                    have_free = 1; free_way = j;
                end
                continue;
            end
            if (shadow_tag[base+j] == tag && !hit) begin
                hit = 1; hit_way = j;
            end
            if (shadow_rank[base+j] >= lru_rank) begin
                lru_rank = int'(shadow_rank[base+j]); lru_way = j;
            end
        end
        if (hit) begin
            promote(base, ways, hit_way, int'(shadow_rank[base+hit_way]));
            shadow_hits++;
        end else if (kind == lrc_pkg::KIND_LOAD || cur_walloc) begin
            if (have_free) begin
                shadow_valid[base+free_way] = 1'b1;
                shadow_tag[base+free_way] = tag;
                promote(base, ways, free_way, ways);
            end else begin
                shadow_tag[base+lru_way] = tag;
                promote(base, ways, lru_way, lru_rank);
            end
        end
        r.hit = hit;
        r.total = shadow_hits;
        return r;
    endfunction

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_results++;
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected result", o_hit_total, 32'd0);
            end else begin
                t_lookup e;
                e = pending_lookups.pop_front();
                if (o_hit) seen_hits++;
                if (o_hit !== e.hit) report_mismatch("hit", 32'(o_hit), 32'(e.hit));
                if (o_hit_total !== e.total)
                    report_mismatch("hit_total", o_hit_total, e.total);
            end
        end
    end

    // one access beat
    task automatic send_access(input logic kind, input logic [31:0] addr);
        i_kind = kind;
        i_address = addr;
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_lookups.insert(pending_lookups.size(), lookup_line(kind, addr));
        sent_accesses++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_lookups.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // config beat, only while idle
    task automatic write_reg(input logic [lrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lrc_pkg::CFG_DAT_W-1:0] val);
        wait_drain();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == lrc_pkg::REG_WAYS_LOG2) begin
            cur_ways_lg = val;
            flush_lines();
        end else if (idx == lrc_pkg::REG_WRITE_ALLOC) begin
            cur_walloc = val[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // address built from a small tag pool so sets fill and evict
    function automatic logic [31:0] pool_addr(int tag_pool);
        logic [31:0] a;
        a = $urandom();
        if ($urandom_range(9) != 0) begin
            a[31:14] = 18'($urandom_range(tag_pool - 1));
            a[13:5] = 9'($urandom_range(3) << ($urandom_range(1) * 2));
        end
        return a;
    endfunction

    task automatic test_directed();
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFE0);
        // three tags into a two-way set: LRU eviction
        send_access(1'b0, 32'h0001_0040);
        send_access(1'b0, 32'h0002_0040);
        send_access(1'b0, 32'h0001_0040);
        send_access(1'b0, 32'h0003_0040);
        send_access(1'b0, 32'h0002_0040);
        send_access(1'b0, 32'h0001_0040);
        // no write allocate: store miss leaves set alone, lines kept
        write_reg(lrc_pkg::REG_WRITE_ALLOC, 4'd0);
        send_access(1'b1, 32'h0005_0080);
        send_access(1'b0, 32'h0005_0080);
        send_access(1'b1, 32'h0001_0040);
        write_reg(lrc_pkg::REG_WRITE_ALLOC, 4'd1);
        // oversized associativity acts as fully associative
        write_reg(lrc_pkg::REG_WAYS_LOG2, 4'd15);
        send_access(1'b0, 32'hAAAA_5555);
        send_access(1'b1, 32'h5555_AAAA);
        send_access(1'b0, 32'hAAAA_5555);
        // direct mapped
        write_reg(lrc_pkg::REG_WAYS_LOG2, 4'd0);
        send_access(1'b0, 32'h1234_5678);
        send_access(1'b0, 32'h1234_5678);
        send_access(1'b1, 32'h8765_4321);
        // index beyond the register list is ignored
        write_reg(2'd3, 4'hF);
        send_access(1'b0, 32'h1234_5678);
    endtask

    task automatic test_random(input int count, input logic [3:0] wl,
                               input logic walloc);
        int burst;
        write_reg(lrc_pkg::REG_WAYS_LOG2, wl);
        write_reg(lrc_pkg::REG_WRITE_ALLOC, {3'b0, walloc});
        while (count > 0) begin
            burst = $urandom_range(12, 1);
            for (int k = 0; k < burst && count > 0; k++, count--)
                send_access(1'($urandom_range(1)), pool_addr(wl > 6 ? 700 : 6));
            if ($urandom_range(2) != 0) repeat ($urandom_range(30)) @(negedge i_clk);
        end
    endtask

    initial begin
        cur_ways_lg = 4'd1;
        cur_walloc = 1'b1;
        shadow_hits = '0;
        flush_lines();
        for (int i = 0; i < lrc_pkg::LINES; i++) begin
            shadow_tag[i] = '0; shadow_rank[i] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(250, 4'd1, 1'b1);
        test_random(250, 4'd2, 1'b0);
        test_random(200, 4'd3, 1'b1);
        test_random(150, 4'd0, 1'b1);
        test_random(100, 4'd4, 1'b0);
        test_random(60,  4'd9, 1'b1);
        test_random(20,  4'd12, 1'b0);
        wait_drain();
        $display("Sent %0d accesses, checked %0d results (%0d hits),",
                 sent_accesses, seen_results, seen_hits);
        $display("direct mapped through fully associative, with and without write allocate.");
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
